// ===== rtl/brb_pkg.sv =====
// Shared types and constants of the byte ring buffer.
package brb_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LEN_W  = 9;
  localparam int BYTE_W = 8;
  localparam int FILL_W = 9;
  localparam int CMP_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic              first_of_run;
    logic [LEN_W-1:0]  run_length;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] read_byte;
    logic              last_of_run;
    logic [FILL_W-1:0] fill_count;
  } out_item_t;

endpackage

// ===== rtl/byte_ring_buffer_bulk.sv =====
// Byte ring buffer with all-or-nothing write, read and peek runs.
//
// One input beat carries one byte position of a run; the first beat of a run
// names its kind and length, and the run is admitted only if the free space
// (write) or the stored bytes (read, peek) cover the whole length, otherwise
// every beat of that run is answered with status 1 and changes nothing. Each
// input beat yields exactly one result beat (status, read byte, last marker,
// fill count after the beat). The block takes one beat per clock cycle: all
// pointer and count updates are done in a single pass between the input port
// and the result register, and the byte store is a single memory written at
// the write pointer and read at the read or peek address in the same cycle,
// its registered read data forming the read byte of the result. A result
// appears in the cycle after its beat is taken; a full result register that is
// not being drained holds the input off. Opcode 3 empties the buffer at once
// and ends any run in progress; no clearing pass follows reset, as the store
// is only ever read at positions written earlier.
module byte_ring_buffer_bulk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  brb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output brb_pkg::out_item_t out_data
);

  // Buffer state
  logic [brb_pkg::ADDR_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [brb_pkg::ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [brb_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [brb_pkg::LEN_W-1:0]  run_left_r, run_left_nxt;
  logic                       run_ok_r, run_ok_nxt;
  logic [brb_pkg::CNT_W-1:0]  peek_off_r, peek_off_nxt;
  logic [1:0]                 run_kind_r, run_kind_nxt;

  // Byte store and its read port
  logic [brb_pkg::BYTE_W-1:0] mem [brb_pkg::DEPTH];
  logic [brb_pkg::BYTE_W-1:0] mem_q_r;
  logic [brb_pkg::ADDR_W-1:0] rd_addr;
  logic                       mem_we;

  // Result register
  logic                       out_valid_r;
  logic                       status_r, status_nxt;
  logic                       rd_hit_r, rd_hit_nxt;
  logic                       last_r, last_nxt;
  logic [brb_pkg::FILL_W-1:0] fill_r, fill_nxt;

  // Per-beat working values
  logic                       acc;
  logic                       is_clear;
  logic                       stray;
  logic [brb_pkg::LEN_W-1:0]  len_eff;
  logic [1:0]                 kind;
  logic                       ok;
  logic [brb_pkg::LEN_W-1:0]  left0;
  logic [brb_pkg::CNT_W-1:0]  poff0;
  logic [brb_pkg::CMP_W-1:0]  free_w;
  logic [brb_pkg::CMP_W-1:0]  count_w;
  logic [brb_pkg::CMP_W-1:0]  len_w;
  logic [brb_pkg::ADDR_W:0]   psum;
  logic [brb_pkg::ADDR_W:0]   psum_adj;
  logic [brb_pkg::CMP_W-1:0]  fill_w;

  // Take a new beat whenever the result register is empty or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  assign is_clear = (in_data.opcode == brb_pkg::OP_CLEAR);
  assign stray    = !in_data.first_of_run && (run_left_r == '0);
  assign len_eff  = (in_data.run_length == '0) ? brb_pkg::LEN_W'(1) : in_data.run_length;

  assign count_w  = brb_pkg::CMP_W'(count_r);
  assign len_w    = brb_pkg::CMP_W'(len_eff);
  assign free_w   = brb_pkg::CMP_W'(brb_pkg::DEPTH) - count_w;

  // A first beat opens a fresh run; later beats follow the stored run.
  assign kind  = in_data.first_of_run ? in_data.opcode : run_kind_r;
  assign left0 = in_data.first_of_run ? len_eff : run_left_r;
  assign poff0 = in_data.first_of_run ? '0 : peek_off_r;
  always_comb begin
    if (!in_data.first_of_run) begin
      ok = run_ok_r;
    end else if (in_data.opcode == brb_pkg::OP_WRITE) begin
      ok = (free_w >= len_w);
    end else begin
      ok = (count_w >= len_w);
    end
  end

  // Peek address: read pointer plus offset, folded back once into the ring.
  assign psum     = (brb_pkg::ADDR_W + 1)'(rd_idx_r) + (brb_pkg::ADDR_W + 1)'(poff0);
  assign psum_adj = (psum >= (brb_pkg::ADDR_W + 1)'(brb_pkg::DEPTH))
                    ? psum - (brb_pkg::ADDR_W + 1)'(brb_pkg::DEPTH) : psum;

  always_comb begin
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    count_nxt    = count_r;
    run_left_nxt = run_left_r;
    run_ok_nxt   = run_ok_r;
    peek_off_nxt = peek_off_r;
    run_kind_nxt = run_kind_r;
    status_nxt   = 1'b0;
    rd_hit_nxt   = 1'b0;
    last_nxt     = 1'b0;
    mem_we       = 1'b0;
    rd_addr      = rd_idx_r;

    if (is_clear) begin
      // Empty the buffer and drop any open run.
      wr_idx_nxt   = '0;
      rd_idx_nxt   = '0;
      count_nxt    = '0;
      run_left_nxt = '0;
      run_ok_nxt   = 1'b0;
      peek_off_nxt = '0;
      last_nxt     = 1'b1;
    end else if (stray) begin
      // Continuation beat with no run open: reject, change nothing.
      status_nxt = 1'b1;
      last_nxt   = 1'b1;
    end else begin
      run_kind_nxt = kind;
      run_ok_nxt   = ok;
      peek_off_nxt = poff0;
      if (ok) begin
        unique case (kind)
          brb_pkg::OP_WRITE: begin
            if (count_r < brb_pkg::CNT_W'(brb_pkg::DEPTH)) begin
              mem_we     = 1'b1;
              wr_idx_nxt = (wr_idx_r == brb_pkg::ADDR_W'(brb_pkg::DEPTH - 1))
                           ? '0 : wr_idx_r + 1'b1;
              count_nxt  = count_r + 1'b1;
            end
          end
          brb_pkg::OP_READ: begin
            if (count_r != '0) begin
              rd_hit_nxt = 1'b1;
              rd_idx_nxt = (rd_idx_r == brb_pkg::ADDR_W'(brb_pkg::DEPTH - 1))
                           ? '0 : rd_idx_r + 1'b1;
              count_nxt  = count_r - 1'b1;
            end
          end
          default: begin
            // Peek: walk an offset from the read pointer, leave the data.
            rd_addr = brb_pkg::ADDR_W'(psum_adj);
            if (poff0 < count_r) begin
              rd_hit_nxt   = 1'b1;
              peek_off_nxt = poff0 + 1'b1;
            end
          end
        endcase
      end else begin
        status_nxt = 1'b1;
      end
      run_left_nxt = left0 - 1'b1;
      if (run_left_nxt == '0) begin
        last_nxt     = 1'b1;
        run_ok_nxt   = 1'b0;
        peek_off_nxt = '0;
      end
    end
  end

  assign fill_w   = brb_pkg::CMP_W'(count_nxt);
  assign fill_nxt = fill_w[brb_pkg::FILL_W-1:0];

  // Byte store: one write and one registered read per cycle, on accepted beats only.
  always_ff @(posedge clk) begin
    if (acc && mem_we) begin
      mem[wr_idx_r] <= in_data.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Advance the buffer state on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      count_r    <= '0;
      run_left_r <= '0;
      run_ok_r   <= 1'b0;
      peek_off_r <= '0;
      run_kind_r <= brb_pkg::OP_WRITE;
    end else if (acc) begin
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      count_r    <= count_nxt;
      run_left_r <= run_left_nxt;
      run_ok_r   <= run_ok_nxt;
      peek_off_r <= peek_off_nxt;
      run_kind_r <= run_kind_nxt;
    end
  end

  // Result register: hold while the far side stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status_nxt;
      rd_hit_r <= rd_hit_nxt;
      last_r   <= last_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_data.status       = status_r;
  assign out_data.read_byte    = rd_hit_r ? mem_q_r : '0;
  assign out_data.last_of_run  = last_r;
  assign out_data.fill_count   = fill_r;

  // The stored count never passes the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= brb_pkg::CNT_W'(brb_pkg::DEPTH))
    else $error("stored count beyond depth");

  // No admitted run outlives its length.
  a_ok_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    (run_left_r == '0) |-> !run_ok_r)
    else $error("run admitted with no beats left");

  // A clear beat reports an empty buffer and closes the run.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_clear) |=> (out_valid && out_data.fill_count == '0 &&
                           out_data.last_of_run && !out_data.status))
    else $error("clear result wrong");

  // A rejected beat leaves the stored count alone.
  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && status_nxt) |=> (count_r == $past(count_r)))
    else $error("rejected beat moved the count");

endmodule
